### design/pfbb_pkg.sv
`default_nettype none
package pfbb_pkg;

  // Request codes of an input transaction
  typedef enum logic [1:0] {
    REQ_BLIT  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int          CFG_IDX_W  = 1;
  localparam logic [7:0]  SW_RESET   = 8'd128;
  localparam logic [7:0]  SH_RESET   = 8'd64;
  localparam logic [7:0]  FULL_BYTE  = 8'hFF;

  // Frame index as computed before the range check (clear can reach 8415)
  localparam int IDX_W     = 14;
  localparam int OUT_IDX_W = 10;

  localparam int OP_DEPTH  = 4;
  localparam int RES_DEPTH = 4;
  localparam int RES_CNT_W = $clog2(RES_DEPTH) + 1;

  // One input transaction
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  dst_x;
    logic [7:0]  dst_y;
    logic [7:0]  src_col;
    logic [4:0]  src_page;
    logic [7:0]  bmp_width;
    logic [7:0]  bmp_height;
    logic        invert;
    logic [7:0]  offset_y;
    logic [7:0]  src_byte;
    logic [9:0]  read_index;
  } item_t;

  // One frame store operation: a bit-run merge or a read
  typedef struct packed {
    logic             is_read;
    logic             rd_zero;
    logic [IDX_W-1:0] idx;
    logic [2:0]       start;
    logic [3:0]       count;
    logic [7:0]       pix;
    logic             last;
  } op_t;

  // One result transaction
  typedef struct packed {
    logic [OUT_IDX_W-1:0] fb_index;
    logic [7:0]           fb_byte;
    logic                 is_write;
    logic                 last;
  } result_t;

endpackage
`default_nettype wire

### design/pfbb_fifo.sv
`default_nettype none
module pfbb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [W-1:0]               din,
  output logic                            full,
  input  wire logic                       pop,
  output logic [W-1:0]                    dout,
  output logic                            empty,
  output logic [$clog2(DEPTH):0]          count
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] slot_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rp_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + AW'(1);
      if (do_pop)  rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= din;
  end

endmodule
`default_nettype wire

### design/pfbb_front.sv
`default_nettype none
module pfbb_front #(
  parameter int FRAME_BYTES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pfbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           push,
  input  wire pfbb_pkg::item_t                item,
  output logic                                full,
  input  wire logic                           clearing,
  output logic                                q_push,
  output pfbb_pkg::op_t                       q_op,
  input  wire logic                           q_full
);

  localparam int IW = pfbb_pkg::IDX_W;
  localparam logic [IW-1:0] FB_LIMIT = IW'(FRAME_BYTES);

  logic [7:0]       sw_r, sh_r;
  pfbb_pkg::item_t  item_r;
  logic             item_v_r, item_v_nxt;
  pfbb_pkg::op_t    pend0_r, pend1_r, dec0, dec1;
  logic             pv0_r, pv1_r, pv0_nxt, pv1_nxt, dv0, dv1;
  logic             accept, item_adv, pend_free;

  // Blit geometry, all rows and columns wrap at 8 bits
  logic [7:0]    pg8, y, endr, top, bot, d_top, d_bot, hrem, xx, mask, pix, pix_hi, tmp;
  logic [2:0]    poff;
  logic [3:0]    poff_room, nb, nb_room, nb2;
  logic [4:0]    mul_a;
  logic [12:0]   prod_a, prod_b;
  logic [IW-1:0] idx_a, idx_b, idx_clr, idx_rd;
  logic          in_bmp, offclip, colclip, top_on, bot_on, direct, blit_ok;
  logic          va, vb, clr_ok;

  assign pg8     = {item_r.src_page, 3'b000};
  assign in_bmp  = (item_r.src_col < item_r.bmp_width) && (pg8 < item_r.bmp_height);
  assign y       = item_r.dst_y - item_r.offset_y;
  assign poff    = y[2:0];
  assign endr    = item_r.dst_y + item_r.bmp_height;
  assign top     = pg8 + y;
  assign bot     = top + 8'd8;
  assign d_top   = item_r.dst_y - top;
  assign d_bot   = bot - endr;
  assign offclip = (item_r.offset_y != 8'd0) &&
                   ((bot < item_r.dst_y) || (bot > sh_r) || (top > endr));
  assign hrem    = item_r.bmp_height - pg8;
  assign xx      = item_r.dst_x + item_r.src_col;
  assign colclip = (xx >= sw_r);
  assign top_on  = (top < sh_r);
  assign bot_on  = (bot < sh_r);
  assign direct  = (poff == 3'd0) && top_on;
  assign blit_ok = in_bmp && !offclip && !colclip;

  // Offset clip mask
  always_comb begin
    mask = pfbb_pkg::FULL_BYTE;
    if (item_r.offset_y != 8'd0) begin
      if (top < item_r.dst_y) begin
        mask = (d_top >= 8'd8) ? 8'h00 : (pfbb_pkg::FULL_BYTE << d_top[2:0]);
      end else if (bot > endr) begin
        mask = (d_bot >= 8'd8) ? 8'h00 : (pfbb_pkg::FULL_BYTE >> d_bot[2:0]);
      end
    end
  end

  assign pix    = (item_r.invert ? ~item_r.src_byte : item_r.src_byte) & mask;
  assign pix_hi = (poff == 3'd0) ? 8'h00 : (pix >> (4'd8 - {1'b0, poff}));

  // Bit counts of the two frame bytes
  assign poff_room = 4'd8 - {1'b0, poff};
  assign nb        = (hrem < {4'b0, poff_room}) ? hrem[3:0] : poff_room;
  assign tmp       = top_on ? (hrem - {4'b0, nb}) : hrem;
  assign nb_room   = 4'd8 - nb;
  assign nb2       = (tmp < {4'b0, nb_room}) ? tmp[3:0] : nb_room;

  // Page row base: one shared multiplier for the first byte or the clear row
  assign mul_a  = (item_r.req_type == pfbb_pkg::REQ_CLEAR) ? item_r.dst_y[7:3] : top[7:3];
  assign prod_a = {8'b0, mul_a} * {5'b0, sw_r};
  assign prod_b = {8'b0, bot[7:3]} * {5'b0, sw_r};

  assign idx_a   = {6'b0, xx} + {1'b0, prod_a};
  assign idx_b   = {6'b0, xx} + {1'b0, prod_b};
  assign idx_clr = {6'b0, item_r.dst_x} + {6'b0, item_r.src_col} + {1'b0, prod_a};
  assign idx_rd  = {4'b0, item_r.read_index};

  assign va     = blit_ok && top_on && (idx_a < FB_LIMIT);
  assign vb     = blit_ok && !direct && (tmp != 8'd0) && bot_on && (idx_b < FB_LIMIT);
  assign clr_ok = (item_r.src_col < item_r.bmp_width) && (idx_clr < FB_LIMIT);

  // Classify the held transaction into up to two operations
  always_comb begin
    dec0 = '0;
    dec1 = '0;
    dv0  = 1'b0;
    dv1  = 1'b0;
    case (item_r.req_type)
      pfbb_pkg::REQ_BLIT: begin
        dv0        = va;
        dec0.idx   = idx_a;
        dec0.start = poff;
        dec0.count = nb;
        dec0.pix   = pix;
        dec0.last  = !vb;
        dv1        = vb;
        dec1.idx   = idx_b;
        dec1.start = 3'd0;
        dec1.count = nb2;
        dec1.pix   = pix_hi;
        dec1.last  = 1'b1;
      end
      pfbb_pkg::REQ_READ: begin
        dv0          = 1'b1;
        dec0.is_read = 1'b1;
        dec0.rd_zero = (idx_rd >= FB_LIMIT);
        dec0.idx     = idx_rd;
        dec0.last    = 1'b1;
      end
      pfbb_pkg::REQ_CLEAR: begin
        dv0        = clr_ok;
        dec0.idx   = idx_clr;
        dec0.count = 4'd8;
        dec0.pix   = 8'h00;
        dec0.last  = 1'b1;
      end
      default: begin
        dv0 = 1'b0;
      end
    endcase
  end

  // Handshake: drain pending operations into the queue one per cycle while it is not full
  assign q_push    = (pv0_r || pv1_r) && !q_full;
  assign q_op      = pv0_r ? pend0_r : pend1_r;
  assign pend_free = !(pv0_r || pv1_r) || (q_push && !(pv0_r && pv1_r));
  assign item_adv  = item_v_r && pend_free;
  assign full      = clearing || (item_v_r && !pend_free);
  assign accept    = push && !full;

  always_comb begin
    item_v_nxt = item_v_r;
    if (accept) begin
      item_v_nxt = 1'b1;
    end else if (item_adv) begin
      item_v_nxt = 1'b0;
    end
    pv0_nxt = pv0_r;
    pv1_nxt = pv1_r;
    if (item_adv) begin
      pv0_nxt = dv0;
      pv1_nxt = dv1;
    end else if (q_push) begin
      if (pv0_r) pv0_nxt = 1'b0;
      else       pv1_nxt = 1'b0;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r     <= pfbb_pkg::SW_RESET;
      sh_r     <= pfbb_pkg::SH_RESET;
      item_v_r <= 1'b0;
      pv0_r    <= 1'b0;
      pv1_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfbb_pkg::CFG_SCREEN_WIDTH:  sw_r <= cfg_data;
          pfbb_pkg::CFG_SCREEN_HEIGHT: sh_r <= cfg_data;
          default: ;
        endcase
      end
      item_v_r <= item_v_nxt;
      pv0_r    <= pv0_nxt;
      pv1_r    <= pv1_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= item;
    if (item_adv) begin
      pend0_r <= dec0;
      pend1_r <= dec1;
    end
  end

endmodule
`default_nettype wire

### design/pfbb_back.sv
`default_nettype none
module pfbb_back #(
  parameter int FRAME_BYTES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           op_empty,
  input  wire pfbb_pkg::op_t                  op,
  output logic                                op_pop,
  output logic                                res_push,
  output pfbb_pkg::result_t                   res,
  input  wire logic [pfbb_pkg::RES_CNT_W-1:0] res_count,
  output logic                                clearing
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = pfbb_pkg::RES_CNT_W;

  logic [7:0]    fb_mem [FRAME_BYTES];
  logic [7:0]    rd_data_r, fwd_data_r, old_byte, new_byte;
  logic          clr_busy_r, fwd_v_r, e1_v_r, issue, e1_wr;
  logic [AW-1:0] clr_addr_r, rd_addr, e1_addr, mem_wa;
  logic          mem_we;
  logic [7:0]    mem_wd;
  pfbb_pkg::op_t e1_op_r;

  function automatic logic [7:0] merge_bits(input logic [7:0] oldv, input logic [7:0] newv,
                                            input logic [2:0] start, input logic [3:0] count);
    logic [7:0]  msk;
    logic [15:0] msh, vsh;
    msk = (count >= 4'd8) ? 8'hFF : 8'((9'd1 << count) - 9'd1);
    msh = {8'b0, msk} << start;
    vsh = {8'b0, newv & msk} << start;
    return (oldv & ~msh[7:0]) | vsh[7:0];
  endfunction

  // Issue stage: start a memory read when the result queue has room
  assign clearing = clr_busy_r;
  assign issue    = !clr_busy_r && !op_empty &&
                    ((res_count + CW'(e1_v_r)) < CW'(pfbb_pkg::RES_DEPTH));
  assign op_pop   = issue;
  assign rd_addr  = op.idx[AW-1:0];
  assign e1_addr  = e1_op_r.idx[AW-1:0];
  assign e1_wr    = e1_v_r && !e1_op_r.is_read;

  // Execute stage: merge with the old byte, bypassing a write still landing
  assign old_byte = fwd_v_r ? fwd_data_r : rd_data_r;
  assign new_byte = merge_bits(old_byte, e1_op_r.pix, e1_op_r.start, e1_op_r.count);

  assign res_push     = e1_v_r;
  assign res.fb_index = e1_op_r.idx[pfbb_pkg::OUT_IDX_W-1:0];
  assign res.fb_byte  = e1_op_r.is_read ? (e1_op_r.rd_zero ? 8'h00 : old_byte) : new_byte;
  assign res.is_write = !e1_op_r.is_read;
  assign res.last     = e1_op_r.last;

  // Write port: clearing pass after reset, then merged bytes
  assign mem_we = clr_busy_r || e1_wr;
  assign mem_wa = clr_busy_r ? clr_addr_r : e1_addr;
  assign mem_wd = clr_busy_r ? 8'h00 : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) fb_mem[mem_wa] <= mem_wd;
    rd_data_r <= fb_mem[rd_addr];
  end

  // Control: clear sweep and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      e1_v_r     <= 1'b0;
      fwd_v_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(FRAME_BYTES - 1)) clr_busy_r <= 1'b0;
      end
      e1_v_r  <= issue;
      fwd_v_r <= issue && e1_wr && (e1_addr == rd_addr);
    end
  end

  // Payload of the execute stage and the bypass byte
  always_ff @(posedge clk) begin
    if (issue) e1_op_r <= op;
    fwd_data_r <= new_byte;
  end

endmodule
`default_nettype wire

### design/page_framebuffer_bitmap_blitter_unit.sv
// Throughput: the frame store executes one read-modify-write per cycle while the result
// queue has room, so a blit that touches two frame bytes needs two operations, and a
// read, clear or single-byte blit needs one.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the frame store,
// one byte per cycle over all FRAME_BYTES addresses, with full held high meanwhile.
`default_nettype none
module page_framebuffer_bitmap_blitter_unit #(
  parameter int FRAME_BYTES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pfbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [1:0]                     in_req_type,
  input  wire logic [7:0]                     in_dst_x,
  input  wire logic [7:0]                     in_dst_y,
  input  wire logic [7:0]                     in_src_col,
  input  wire logic [4:0]                     in_src_page,
  input  wire logic [7:0]                     in_bmp_width,
  input  wire logic [7:0]                     in_bmp_height,
  input  wire logic                           in_invert,
  input  wire logic [7:0]                     in_offset_y,
  input  wire logic [7:0]                     in_src_byte,
  input  wire logic [9:0]                     in_read_index,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [9:0]                          out_fb_index,
  output logic [7:0]                          out_fb_byte,
  output logic                                out_is_write,
  output logic                                out_last
);

  localparam int OPW  = $bits(pfbb_pkg::op_t);
  localparam int RESW = $bits(pfbb_pkg::result_t);

  pfbb_pkg::item_t             item;
  pfbb_pkg::op_t               fq_op, bq_op;
  pfbb_pkg::result_t           be_res, out_res;
  logic [OPW-1:0]              bq_vec;
  logic [RESW-1:0]             out_vec;
  logic                        fq_push, fq_full, op_empty, op_pop, clearing;
  logic                        res_push;
  logic [pfbb_pkg::RES_CNT_W-1:0] res_count;

  // Gather the input transaction
  assign item.req_type   = in_req_type;
  assign item.dst_x      = in_dst_x;
  assign item.dst_y      = in_dst_y;
  assign item.src_col    = in_src_col;
  assign item.src_page   = in_src_page;
  assign item.bmp_width  = in_bmp_width;
  assign item.bmp_height = in_bmp_height;
  assign item.invert     = in_invert;
  assign item.offset_y   = in_offset_y;
  assign item.src_byte   = in_src_byte;
  assign item.read_index = in_read_index;

  pfbb_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .clearing  (clearing),
    .q_push    (fq_push),
    .q_op      (fq_op),
    .q_full    (fq_full)
  );

  pfbb_fifo #(.W(OPW), .DEPTH(pfbb_pkg::OP_DEPTH)) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (OPW'(fq_op)),
    .full  (fq_full),
    .pop   (op_pop),
    .dout  (bq_vec),
    .empty (op_empty),
    .count ()
  );

  assign bq_op = pfbb_pkg::op_t'(bq_vec);

  pfbb_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_empty  (op_empty),
    .op        (bq_op),
    .op_pop    (op_pop),
    .res_push  (res_push),
    .res       (be_res),
    .res_count (res_count),
    .clearing  (clearing)
  );

  pfbb_fifo #(.W(RESW), .DEPTH(pfbb_pkg::RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (RESW'(be_res)),
    .full  (),
    .pop   (pop),
    .dout  (out_vec),
    .empty (empty),
    .count (res_count)
  );

  // Drive the result ports
  assign out_res      = pfbb_pkg::result_t'(out_vec);
  assign out_fb_index = out_res.fb_index;
  assign out_fb_byte  = out_res.fb_byte;
  assign out_is_write = out_res.is_write;
  assign out_last     = out_res.last;

endmodule
`default_nettype wire

### design/pfbb_checker.sv
`default_nettype none
module pfbb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_we,
  input wire logic [0:0] cfg_index,
  input wire logic [7:0] cfg_data,
  input wire logic       push,
  input wire logic       full,
  input wire logic [1:0] in_req_type,
  input wire logic [7:0] in_dst_x,
  input wire logic [7:0] in_dst_y,
  input wire logic [7:0] in_src_col,
  input wire logic [4:0] in_src_page,
  input wire logic [7:0] in_bmp_width,
  input wire logic [7:0] in_bmp_height,
  input wire logic       in_invert,
  input wire logic [7:0] in_offset_y,
  input wire logic [7:0] in_src_byte,
  input wire logic [9:0] in_read_index,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [9:0] out_fb_index,
  input wire logic [7:0] out_fb_byte,
  input wire logic       out_is_write,
  input wire logic       out_last
);

  // Reset starts the clearing pass, which refuses input
  a_reset_full: assert property (@(posedge clk) !rst_n |=> full)
    else $error("input not refused after reset");

  // Reset drops all waiting results
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results present after reset");

  // A read answer is always the only result of its transaction
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_is_write) |-> out_last)
    else $error("read answer not marked last");

  // Only a blit gives a result that is not the last one, and that is a write
  a_nonlast_write: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> out_is_write)
    else $error("non-final result is not a write");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_fb_index) && $stable(out_fb_byte)))
    else $error("waiting result changed");

endmodule

bind page_framebuffer_bitmap_blitter_unit pfbb_checker u_pfbb_checker (.*);
`default_nettype wire
